### rtl/bce_pkg.sv
package bce_pkg;

   localparam int unsigned QUEUE_DEPTH = 2;

   localparam logic signed [31:0] MIN_BASE   = 32'sd157680000;
   localparam logic signed [31:0] SUBST_BASE = 32'sd205329600;
   localparam logic [32:0]        DRIFT_LIMIT = 33'd172800;
   localparam logic [16:0]        SEC_DAY    = 17'd86400;
   localparam logic [7:0]         EPOCH_YEAR = 8'd70;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_CLOCK_BAD  = 3'd1;
   localparam logic [2:0] ST_BOTH_BAD   = 3'd2;
   localparam logic [2:0] ST_BASE_BAD   = 3'd3;
   localparam logic [2:0] ST_LOST       = 3'd4;
   localparam logic [2:0] ST_GAINED     = 3'd5;

   typedef struct packed {
      logic              kind;
      logic              bad_base;
      logic              bad_clock;
      logic signed [31:0] time_value;
      logic signed [31:0] base;
      logic [7:0]        sec;
      logic [7:0]        min;
      logic [7:0]        hour;
      logic [7:0]        day;
      logic [7:0]        mon;
      logic [7:0]        year;
   } item_type;

   function automatic logic [8:0] month_start(input logic [3:0] idx);
      logic [8:0] v;
      case (idx)
         4'd0:    v = 9'd0;
         4'd1:    v = 9'd31;
         4'd2:    v = 9'd59;
         4'd3:    v = 9'd90;
         4'd4:    v = 9'd120;
         4'd5:    v = 9'd151;
         4'd6:    v = 9'd181;
         4'd7:    v = 9'd212;
         4'd8:    v = 9'd243;
         4'd9:    v = 9'd273;
         4'd10:   v = 9'd304;
         4'd11:   v = 9'd334;
         default: v = 9'd0;
      endcase
      return v;
   endfunction

   function automatic logic [7:0] bcd_dec(input logic [7:0] b);
      return 8'(b[7:4]) * 8'd10 + 8'(b[3:0]);
   endfunction

   function automatic logic [7:0] bcd_enc(input logic [7:0] n);
      logic [7:0] tens;
      logic [7:0] t2;
      logic [7:0] ones;
      tens = 8'((16'(n) * 16'd205) >> 11);
      if (tens >= 8'd20) t2 = tens - 8'd20;
      else if (tens >= 8'd10) t2 = tens - 8'd10;
      else t2 = tens;
      ones = n - 8'(tens * 8'd10);
      return {t2[3:0], ones[3:0]};
   endfunction

   function automatic logic [8:0] year_len(input logic [7:0] yr);
      return (yr[1:0] == 2'b00) ? 9'd366 : 9'd365;
   endfunction

endpackage

### rtl/bce_front.sv
module bce_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic                kind,
   input  logic [31:0]         time_value,
   input  logic [7:0]          clock_sec,
   input  logic [7:0]          clock_min,
   input  logic [7:0]          clock_hour,
   input  logic [7:0]          clock_day,
   input  logic [7:0]          clock_month,
   input  logic [7:0]          clock_year,
   output logic                q_valid,
   input  logic                q_pop,
   output bce_pkg::item_type   q_item
);

   bce_pkg::item_type mem [bce_pkg::QUEUE_DEPTH];
   bce_pkg::item_type item;
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   function automatic logic [7:0] bcd_pkg_dec(input logic [7:0] b);
      return bce_pkg::bcd_dec(b);
   endfunction

   always_comb begin
      item.kind       = kind;
      item.time_value = time_value;
      item.sec        = bcd_pkg_dec(clock_sec);
      item.min        = bcd_pkg_dec(clock_min);
      item.hour       = bcd_pkg_dec(clock_hour);
      item.day        = bcd_pkg_dec(clock_day);
      item.mon        = bcd_pkg_dec(clock_month);
      item.year       = bcd_pkg_dec(clock_year);
      item.bad_base   = $signed(time_value) < bce_pkg::MIN_BASE;
      item.base       = item.bad_base ? bce_pkg::SUBST_BASE : $signed(time_value);
      item.bad_clock  = (item.year < bce_pkg::EPOCH_YEAR) || (item.mon < 8'd1) ||
                        (item.mon > 8'd12) || (item.day < 8'd1) || (item.day > 8'd31) ||
                        (item.hour > 8'd23) || (item.min > 8'd59) || (item.sec > 8'd59);
   end

   assign in_ready = count_ff != 2'(bce_pkg::QUEUE_DEPTH);
   assign push     = in_valid && in_ready;
   assign q_valid  = count_ff != 2'd0;
   assign pop      = q_pop && q_valid;
   assign q_item   = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= item;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'(bce_pkg::QUEUE_DEPTH))
      else $error("queue count over depth");

endmodule

### rtl/bce_back.sv
module bce_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   output logic                q_pop,
   input  bce_pkg::item_type   q_item,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [103:0]        out_data
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_YEARS  = 4'd1;
   localparam logic [3:0] S_MUL    = 4'd2;
   localparam logic [3:0] S_DIFF   = 4'd3;
   localparam logic [3:0] S_DIV    = 4'd4;
   localparam logic [3:0] S_REM    = 4'd5;
   localparam logic [3:0] S_YSPLIT = 4'd6;
   localparam logic [3:0] S_MONTH  = 4'd7;
   localparam logic [3:0] S_HOUR   = 4'd8;
   localparam logic [3:0] S_HREM   = 4'd9;
   localparam logic [3:0] S_MIN    = 4'd10;
   localparam logic [3:0] S_SEC    = 4'd11;
   localparam logic [3:0] S_ENC    = 4'd12;
   localparam logic [3:0] S_DONE   = 4'd13;

   // reciprocals: (x >> 7) / 675, x / 3600, x / 60
   localparam logic [26:0] DAY_RECIP  = 27'd101806633;
   localparam logic [17:0] HOUR_RECIP = 18'd149131;
   localparam logic [12:0] MIN_RECIP  = 13'd4370;

   logic [3:0]         state_ff, state_in;
   bce_pkg::item_type  rec_ff, rec_in;
   logic [32:0]        acc_ff, acc_in;
   logic [15:0]        q_ff, q_in;
   logic [7:0]         yr_ff, yr_in;
   logic               mode_bcd_ff, mode_bcd_in;
   logic [4:0]         hour_ff, hour_in;
   logic [5:0]         min_ff, min_in;
   logic signed [31:0] result_ff, result_in;
   logic [2:0]         status_ff, status_in;
   logic [15:0]        drift_ff, drift_in;
   logic               wr_ff, wr_in;
   logic [7:0]         o_sec_ff, o_sec_in, o_min_ff, o_min_in, o_hour_ff, o_hour_in;
   logic [7:0]         o_day_ff, o_day_in, o_mon_ff, o_mon_in, o_year_ff, o_year_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [103:0]       rsp_data_ff, rsp_data_in;

   logic [52:0] day_prod;
   logic [34:0] hour_prod;
   logic [24:0] min_prod;
   logic [32:0] rem_day, rem_hour, rem_min;
   logic        leap;
   logic [3:0]  mon_sel;
   logic [8:0]  day_v;
   logic [32:0] diff, diff_abs;
   logic [32:0] prod;
   logic        slot_free;

   assign q_pop     = (state_ff == S_IDLE) && q_valid;
   assign slot_free = !rsp_valid_ff || out_ready;

   always_comb begin
      state_in    = state_ff;
      rec_in      = rec_ff;
      acc_in      = acc_ff;
      q_in        = q_ff;
      yr_in       = yr_ff;
      mode_bcd_in = mode_bcd_ff;
      hour_in     = hour_ff;
      min_in      = min_ff;
      result_in   = result_ff;
      status_in   = status_ff;
      drift_in    = drift_ff;
      wr_in       = wr_ff;
      o_sec_in    = o_sec_ff;
      o_min_in    = o_min_ff;
      o_hour_in   = o_hour_ff;
      o_day_in    = o_day_ff;
      o_mon_in    = o_mon_ff;
      o_year_in   = o_year_ff;
      rsp_valid_in = rsp_valid_ff && !out_ready;
      rsp_data_in  = rsp_data_ff;

      day_prod  = 53'(acc_ff[32:7]) * 53'(DAY_RECIP);
      hour_prod = 35'(acc_ff[16:0]) * 35'(HOUR_RECIP);
      min_prod  = 25'(acc_ff[11:0]) * 25'(MIN_RECIP);
      rem_day   = acc_ff - 33'(q_ff) * 33'(bce_pkg::SEC_DAY);
      rem_hour  = acc_ff - 33'(hour_ff) * 33'd3600;
      rem_min   = acc_ff - 33'(min_ff) * 33'd60;
      leap     = yr_ff[1:0] == 2'b00;
      diff     = {result_ff[31], result_ff} - {rec_ff.base[31], rec_ff.base};
      diff_abs = diff[32] ? (33'd0 - diff) : diff;
      prod     = 33'(acc_ff[15:0]) * 33'(bce_pkg::SEC_DAY) + 33'(rec_ff.hour) * 33'd3600 +
                 33'(rec_ff.min) * 33'd60 + 33'(rec_ff.sec);
      mon_sel  = 4'd12;
      for (int m = 11; m >= 1; m--) begin
         if (9'(q_ff) < bce_pkg::month_start(4'(m)) + 9'((leap && m > 1) ? 1 : 0)) begin
            mon_sel = 4'(m);
         end
      end
      day_v    = 9'(q_ff) - bce_pkg::month_start(mon_sel - 4'd1) + 9'd1 -
                 9'((leap && mon_sel > 4'd2) ? 1 : 0);

      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               rec_in    = q_item;
               result_in = q_item.time_value;
               status_in = bce_pkg::ST_OK;
               drift_in  = 16'd0;
               wr_in     = 1'b0;
               o_sec_in  = 8'd0;
               o_min_in  = 8'd0;
               o_hour_in = 8'd0;
               o_day_in  = 8'd0;
               o_mon_in  = 8'd0;
               o_year_in = 8'd0;
               q_in      = 16'd0;
               mode_bcd_in = 1'b1;
               if (q_item.kind) begin
                  acc_in   = q_item.time_value[31] ? 33'd0 : 33'(q_item.time_value);
                  wr_in    = 1'b1;
                  state_in = S_DIV;
               end else if (q_item.bad_clock) begin
                  result_in = q_item.base;
                  if (q_item.bad_base) begin
                     status_in = bce_pkg::ST_BOTH_BAD;
                     state_in  = S_DONE;
                  end else begin
                     status_in = bce_pkg::ST_CLOCK_BAD;
                     wr_in     = 1'b1;
                     acc_in    = 33'(q_item.base);
                     state_in  = S_DIV;
                  end
               end else begin
                  yr_in    = bce_pkg::EPOCH_YEAR;
                  acc_in   = 33'(bce_pkg::month_start(4'(q_item.mon - 8'd1))) +
                             33'(q_item.day) - 33'd1 +
                             33'((q_item.year[1:0] == 2'b00 && q_item.mon > 8'd2) ? 1 : 0);
                  state_in = S_YEARS;
               end
            end
         end
         S_YEARS: begin
            if (yr_ff < rec_ff.year) begin
               acc_in = acc_ff + 33'(bce_pkg::year_len(yr_ff));
               yr_in  = yr_ff + 8'd1;
            end else begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            result_in = signed'(prod[31:0]);
            if (rec_ff.bad_base) begin
               status_in = bce_pkg::ST_BASE_BAD;
               state_in  = S_DONE;
            end else begin
               state_in = S_DIFF;
            end
         end
         S_DIFF: begin
            acc_in      = diff_abs;
            status_in   = (diff_abs >= bce_pkg::DRIFT_LIMIT) ?
                          (diff[32] ? bce_pkg::ST_LOST : bce_pkg::ST_GAINED) : bce_pkg::ST_OK;
            mode_bcd_in = 1'b0;
            q_in        = 16'd0;
            state_in    = S_DIV;
         end
         S_DIV: begin
            q_in = day_prod[51:36];
            if (mode_bcd_ff) begin
               state_in = S_REM;
            end else begin
               drift_in = day_prod[51:36];
               state_in = S_DONE;
            end
         end
         S_REM: begin
            acc_in   = rem_day;
            yr_in    = bce_pkg::EPOCH_YEAR;
            state_in = S_YSPLIT;
         end
         S_YSPLIT: begin
            if (q_ff >= 16'(bce_pkg::year_len(yr_ff))) begin
               q_in  = q_ff - 16'(bce_pkg::year_len(yr_ff));
               yr_in = yr_ff + 8'd1;
            end else begin
               state_in = S_MONTH;
            end
         end
         S_MONTH: begin
            o_day_in  = bce_pkg::bcd_enc(day_v[7:0]);
            o_mon_in  = bce_pkg::bcd_enc(8'(mon_sel));
            o_year_in = bce_pkg::bcd_enc(yr_ff);
            state_in  = S_HOUR;
         end
         S_HOUR: begin
            hour_in  = hour_prod[33:29];
            state_in = S_HREM;
         end
         S_HREM: begin
            acc_in    = rem_hour;
            o_hour_in = bce_pkg::bcd_enc(8'(hour_ff));
            state_in  = S_MIN;
         end
         S_MIN: begin
            min_in   = min_prod[23:18];
            state_in = S_SEC;
         end
         S_SEC: begin
            acc_in   = rem_min;
            o_min_in = bce_pkg::bcd_enc(8'(min_ff));
            state_in = S_ENC;
         end
         S_ENC: begin
            o_sec_in = bce_pkg::bcd_enc(acc_ff[7:0]);
            state_in = S_DONE;
         end
         S_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {3'd0, o_year_ff, o_mon_ff, o_day_ff, 1'b0, o_hour_ff,
                               o_min_ff, o_sec_ff, wr_ff, drift_ff, status_ff, result_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff      <= rec_in;
      acc_ff      <= acc_in;
      q_ff        <= q_in;
      yr_ff       <= yr_in;
      mode_bcd_ff <= mode_bcd_in;
      hour_ff     <= hour_in;
      min_ff      <= min_in;
      result_ff   <= result_in;
      status_ff   <= status_in;
      drift_ff    <= drift_in;
      wr_ff       <= wr_in;
      o_sec_ff    <= o_sec_in;
      o_min_ff    <= o_min_in;
      o_hour_ff   <= o_hour_in;
      o_day_ff    <= o_day_in;
      o_mon_ff    <= o_mon_in;
      o_year_ff   <= o_year_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign out_valid = rsp_valid_ff;
   assign out_data  = rsp_data_ff;

   a_pop_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> state_ff != S_IDLE)
      else $error("popped word left no work");

   a_no_write_zero_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff[51] |-> rsp_data_ff[100:52] == 49'd0)
      else $error("unused clock fields not zero");

   a_both_bad_no_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff[34:32] == bce_pkg::ST_BOTH_BAD |-> !rsp_data_ff[51])
      else $error("write requested with bad base and clock");

   a_drift_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff[34:32] == bce_pkg::ST_LOST ||
                       rsp_data_ff[34:32] == bce_pkg::ST_GAINED) |-> rsp_data_ff[50:35] >= 16'd2)
      else $error("drift status with under two days");

endmodule

### rtl/bcd_calendar_epoch_converter.sv
// timing: each word's run is set by the year-by-year day loop of a clock date
// or by the year split of a seconds value into a date; the day divide
// and the h/m/s split are short reciprocal-multiply steps
// flow: one word in flight in the back end, which takes the next only when done;
// a 2-word queue in front accepts further words while it works
// reset: synchronous, active high; clears queue, sequencer and output valid
module bcd_calendar_epoch_converter (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [79:0]  req_tdata,  // time_value, clock_sec, clock_min, clock_hour,
                                    // clock_day, clock_month, clock_year
   input  logic [0:0]   req_tuser,  // kind
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata   // seconds_out, status, drift_days, write_clock,
                                    // out_sec, out_min, out_hour, out_weekday,
                                    // out_day, out_month, out_year, zero pad
);

   logic              q_valid;
   logic              q_pop;
   bce_pkg::item_type q_item;

   bce_front u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .kind        (req_tuser[0]),
      .time_value  (req_tdata[31:0]),
      .clock_sec   (req_tdata[39:32]),
      .clock_min   (req_tdata[47:40]),
      .clock_hour  (req_tdata[55:48]),
      .clock_day   (req_tdata[63:56]),
      .clock_month (req_tdata[71:64]),
      .clock_year  (req_tdata[79:72]),
      .q_valid     (q_valid),
      .q_pop       (q_pop),
      .q_item      (q_item)
   );

   bce_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .q_item    (q_item),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_tdata)
   );

endmodule
